// ----- hw/rtl/lurt_pkg.sv -----
// lurt_pkg: shared constants and types for the longest unique run tracker
// no dependencies; imported by every module of the block

package lurt_pkg;

  // alphabet and position sizing
  localparam int unsigned ALPHABET = 256;
  localparam int unsigned CODE_W   = $clog2(ALPHABET);
  localparam int unsigned POS_W    = 16;
  localparam logic [POS_W-1:0] MAX_LEN = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_SAT = MAX_LEN - 16'd1;

  // write port into the last-position table
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    logic [POS_W-1:0]  data;
  } pos_wr_t;

  // one result item
  typedef struct packed {
    logic             overflow;
    logic             is_final;
    logic [POS_W-1:0] best_length;
    logic [POS_W-1:0] run_length;
  } result_t;

endpackage

// ----- hw/rtl/lurt_pos_mem.sv -----
// lurt_pos_mem: last-position table, one write and one registered read per cycle
// depends on lurt_pkg

module lurt_pos_mem import lurt_pkg::*; (
  input  logic              clk,
  input  pos_wr_t           wr,
  input  logic              rd_en,
  input  logic [CODE_W-1:0] rd_addr,
  output logic [POS_W-1:0]  rd_data
);

  logic [POS_W-1:0] mem [ALPHABET];

  // write port, read returns the contents before this edge's write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/lurt_core.sv -----
// lurt_core: per-string window state, valid bits and the per-byte update
// depends on lurt_pkg; drives the write port of lurt_pos_mem

module lurt_core import lurt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [CODE_W-1:0] code,
  input  logic              last,
  input  logic [POS_W-1:0]  last_pos,
  output pos_wr_t           wr,
  output result_t           res
);

  logic [ALPHABET-1:0] seen_valid;
  logic [POS_W-1:0]    window_start;
  logic [POS_W-1:0]    char_index;
  logic [POS_W-1:0]    best_so_far;
  logic                overflow_seen;

  logic [POS_W-1:0]    window_start_next;
  logic [POS_W-1:0]    char_index_next;
  logic [POS_W-1:0]    best_so_far_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    ws_hit;
  logic [POS_W:0]      lp_plus;
  logic [POS_W-1:0]    run;
  logic                sat;
  logic                hit;

  // position, window move and run length for this byte
  always_comb begin
    sat     = (char_index >= MAX_LEN);
    pos     = sat ? POS_SAT : char_index;
    char_index_next = sat ? char_index : char_index + 16'd1;
    hit     = seen_valid[code] && (last_pos >= window_start);
    lp_plus = {1'b0, last_pos} + 17'd1;
    ws_hit  = (lp_plus > {1'b0, pos}) ? pos : lp_plus[POS_W-1:0];
    window_start_next = hit ? ws_hit : window_start;
    if (window_start_next > pos) begin
      window_start_next = pos;
    end
    run = pos - window_start_next + 16'd1;
    best_so_far_next = (run > best_so_far) ? run : best_so_far;
  end

  // table write and result
  always_comb begin
    wr.en   = fire;
    wr.addr = code;
    wr.data = pos;
    res.run_length  = run;
    res.best_length = best_so_far_next;
    res.is_final    = last;
    res.overflow    = overflow_seen | sat;
  end

  // state update, everything clears after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid    <= '0;
      window_start  <= '0;
      char_index    <= '0;
      best_so_far   <= '0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      if (last) begin
        seen_valid    <= '0;
        window_start  <= '0;
        char_index    <= '0;
        best_so_far   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        seen_valid[code] <= 1'b1;
        window_start     <= window_start_next;
        char_index       <= char_index_next;
        best_so_far      <= best_so_far_next;
        overflow_seen    <= overflow_seen | sat;
      end
    end
  end

endmodule

// ----- hw/rtl/longest_unique_run_tracker.sv -----
// longest_unique_run_tracker: top level, input stage, forwarding and result register
// depends on lurt_pkg, lurt_pos_mem and lurt_core
//
// Usage:
//   s_axis carries one string byte per transaction; s_axis_tlast marks the
//   final byte of a string. m_axis returns exactly one result per byte:
//   the repeat-free run ending at that byte and the best run so far, with
//   m_axis_tlast set on the final byte's result (best_length is then the
//   answer for the string) and m_axis_tuser flagging a string longer than
//   MAX_LEN, whose positions saturate. Empty strings produce nothing.
//   Path: an accepted byte enters the input stage while its table entry is
//   read; when it fires, the core updates and the result register takes it.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   single read, compare and write of the last-position table per byte; a
//   same-byte read right after a write is served by a forwarding register.
//   Reset clears the window state, the valid bits and both pipeline stages.
//   When the receiver stalls, the result register holds and the input stage
//   fills; s_axis_tready drops only once both are occupied.

module longest_unique_run_tracker import lurt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] run_length, [31:16] best_length
  output logic        m_axis_tlast,   // is_final
  output logic [0:0]  m_axis_tuser    // [0] overflow
);

  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  logic              s1_last;
  logic              fwd_hit;
  logic [POS_W-1:0]  fwd_pos;
  logic [POS_W-1:0]  rd_data;
  logic [POS_W-1:0]  last_pos;
  logic [CODE_W-1:0] in_code;
  logic              accept;
  logic              fire;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  pos_wr_t           wr;

  // handshake control
  assign in_code       = s_axis_tdata[CODE_W-1:0];
  assign fire          = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // table read for the incoming byte
  lurt_pos_mem u_pos_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (in_code),
    .rd_data (rd_data)
  );

  // bypass when the byte now being retired writes the entry just read
  assign last_pos = fwd_hit ? fwd_pos : rd_data;

  lurt_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .code     (s1_code),
    .last     (s1_last),
    .last_pos (last_pos),
    .wr       (wr),
    .res      (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code <= in_code;
      s1_last <= s_axis_tlast;
      fwd_hit <= fire && (s1_code == in_code);
      fwd_pos <= wr.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  // output transaction
  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {out_res.best_length, out_res.run_length};
  assign m_axis_tlast    = out_res.is_final;
  assign m_axis_tuser[0] = out_res.overflow;

endmodule

// ----- verif/tb_longest_unique_run_tracker.sv -----
// tb_longest_unique_run_tracker: self-checking bench for the longest unique run tracker
// depends on lurt_pkg and longest_unique_run_tracker; predicts each result in-bench
// directed strings, one string past MAX_LEN, then random strings under random idling
`timescale 1ns / 100ps

module tb_longest_unique_run_tracker;
  import lurt_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       eos;
  } string_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [15:0] run_length, [31:16] best_length
  logic        m_axis_tlast;           // is_final
  logic [0:0]  m_axis_tuser;           // [0] overflow

  string_byte_t pending_bytes[$];
  result_t      expected_runs[$];
  int           send_idle_pct = 38;
  int           recv_stall_pct = 38;
  int           fail_count = 0;

  // predicted tracker state
  int last_pos [ALPHABET];
  bit pos_valid [ALPHABET];
  int win_start;
  int chars_taken;
  int best_run;
  bit overflow_hit;

  longest_unique_run_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // per-string state clears at reset and after the final byte
  function automatic void clear_window();
    foreach (pos_valid[i]) pos_valid[i] = 1'b0;
    win_start = 0;
    chars_taken = 0;
    best_run = 0;
    overflow_hit = 1'b0;
  endfunction

  // advance the sliding window by one byte and queue the expected result
  function automatic void track_unique_run(logic [7:0] code, logic eos);
    int      pos;
    int      next;
    result_t res;
    if (chars_taken >= int'(MAX_LEN)) begin
      pos = int'(POS_SAT);
      overflow_hit = 1'b1;
    end else begin
      pos = chars_taken;
      chars_taken++;
    end
    if (pos_valid[code] && last_pos[code] >= win_start) begin
      next = last_pos[code] + 1;
      win_start = (next > pos) ? pos : next;
    end
    if (win_start > pos) win_start = pos;
    if (pos - win_start + 1 > best_run) best_run = pos - win_start + 1;
    last_pos[code] = pos;
    pos_valid[code] = 1'b1;
    res.run_length  = 16'(pos - win_start + 1);
    res.best_length = 16'(best_run);
    res.is_final    = eos;
    res.overflow    = overflow_hit;
    expected_runs.push_back(res);
    if (eos) clear_window();
  endfunction

  task automatic check_field(string field, int exp_val, int act_val);
    if (exp_val != act_val) begin
      fail_count++;
      if (fail_count <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
    end
  endtask

  // driver: hold a transaction until taken, then offer the next byte or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      clear_window();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_unique_run(s_axis_tdata, s_axis_tlast);
        void'(pending_bytes.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes[0].code;
          s_axis_tlast  <= pending_bytes[0].eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        fail_count++;
        if (fail_count <= 100)
          $display("%0t: unexpected result, expected none, actual run %0d best %0d",
                   $time, m_axis_tdata[15:0], m_axis_tdata[31:16]);
      end else begin
        check_field("run_length", expected_runs[0].run_length, m_axis_tdata[15:0]);
        check_field("best_length", expected_runs[0].best_length, m_axis_tdata[31:16]);
        check_field("is_final", expected_runs[0].is_final, m_axis_tlast);
        check_field("overflow", expected_runs[0].overflow, m_axis_tuser[0]);
        void'(expected_runs.pop_front());
      end
    end
  end

  task automatic add_byte(logic [7:0] code, logic eos);
    string_byte_t b;
    b.code = code;
    b.eos  = eos;
    pending_bytes.push_back(b);
  endtask

  task automatic wait_all_results();
    while (pending_bytes.size() != 0 || expected_runs.size() != 0) @(posedge clk);
  endtask

  task automatic wait_bytes_taken();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // random strings: mostly short with a varied repeat rate, some full permutations
  task automatic add_random_strings(int target_bytes);
    int     added;
    int     len;
    int     span;
    int     base;
    int     pick;
    int     j;
    logic [7:0] perm [256];
    logic [7:0] tmp;
    added = 0;
    while (added < target_bytes) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        foreach (perm[i]) perm[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        len = 256 + $urandom_range(20);
        for (int i = 0; i < len; i++)
          add_byte((i < 256) ? perm[i] : 8'($urandom_range(255)), i == len - 1);
      end else begin
        if (pick < 70) begin
          len  = $urandom_range(1, 16);
          span = $urandom_range(1, 256);
        end else begin
          len  = $urandom_range(17, 80);
          span = $urandom_range(2, 64);
        end
        base = $urandom_range(255);
        for (int i = 0; i < len; i++)
          add_byte(8'(base + $urandom_range(span - 1)), i == len - 1);
      end
      added += len;
    end
  endtask

  initial begin
    int long_len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: single-byte strings at both extremes
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    // back-to-back repeat, repeat inside the window
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // repeat whose last position lies before the window start
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h01, 1'b1);
    // bytes seen in the previous string start fresh
    add_byte(8'h01, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h55, 1'b1);
    // one long unbroken run of distinct bytes
    for (int i = 0; i < 8; i++) add_byte(8'(1 << i), i == 7);
    wait_all_results();

    // one string past MAX_LEN: positions saturate and overflow sets
    long_len = int'(MAX_LEN) + 1 + $urandom_range(8);
    for (int i = 0; i < long_len; i++) add_byte(8'($urandom_range(255)), i == long_len - 1);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h7E, 1'b1);
    wait_all_results();

    // random strings, with a stretch where neither side idles
    add_random_strings(900);
    wait_bytes_taken();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_strings(500);
    wait_bytes_taken();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    add_random_strings(600);
    wait_all_results();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
